### hdl/sbus_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder modules.
// Each use expands to one labeled concurrent assertion on the block clock.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define SFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/sfd_pkg.sv
`timescale 1ns / 1ps
package sfd_pkg;

   // fixed field widths
   localparam int POS_BITS     = 5;
   localparam int CHAN_BITS    = 11;
   localparam int NUMBER_BITS  = 4;
   localparam int VALUE_BITS   = 12;

   // queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = 2;
   localparam int QCOUNT_BITS  = 3;

   // register file
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_HEADER  = 2'd0;
   localparam logic [1:0] REG_FOOTER  = 2'd1;
   localparam logic [1:0] REG_NEUTRAL = 2'd2;

   // reset values
   localparam logic [7:0]           HEADER_RESET  = 8'h0F;
   localparam logic [7:0]           FOOTER_RESET  = 8'h00;
   localparam logic [CHAN_BITS-1:0] NEUTRAL_RESET = 11'd992;
   localparam logic [7:0]           PREV_RESET    = 8'hFF;

   typedef logic [POS_BITS-1:0] pos_type;

   // one classified byte on its way to the back end
   typedef struct packed {
      logic [7:0] data;
      pos_type    pos;
      logic       complete;
   } entry_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [7:0]           header_value;
      logic [7:0]           footer_value;
      logic [CHAN_BITS-1:0] neutral_offset;
   } cfg_type;

endpackage

### hdl/sfd_front.sv
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"
module sfd_front #(
   parameter int FRAME_BYTES = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_received_byte,
   input  sfd_pkg::cfg_type   cfg,
   input  logic               full,
   output logic               push,
   output sfd_pkg::entry_type push_entry
);
   import sfd_pkg::*;

   localparam pos_type LAST_POS = POS_BITS'(FRAME_BYTES - 1);

   pos_type    pos_ff, pos_in;
   logic [7:0] prev_ff, prev_in;
   logic       restart;

   assign req_ready = !full;
   assign push      = req_valid && !full;

   // frame position: restart on header after footer, else advance and wrap
   assign restart = (req_received_byte == cfg.header_value) &&
                    (prev_ff == cfg.footer_value);

   always_comb begin
      pos_in  = pos_ff;
      prev_in = prev_ff;
      if (push) begin
         prev_in = req_received_byte;
         if (restart || pos_ff >= LAST_POS) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign push_entry.data     = req_received_byte;
   assign push_entry.pos      = pos_in;
   assign push_entry.complete = (pos_in == LAST_POS) &&
                                (req_received_byte == cfg.footer_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= PREV_RESET;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
      end
   end

   `SFD_ASSERT(a_pos_range, pos_ff <= LAST_POS, "frame position beyond last slot")

endmodule

### hdl/sfd_queue.sv
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"
module sfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output sfd_pkg::entry_type pop_entry,
   output logic               empty
);
   import sfd_pkg::*;

   entry_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_BITS-1:0] count_ff;

   assign full      = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `SFD_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
   `SFD_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")

endmodule

### hdl/sfd_back.sv
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"
module sfd_back #(
   parameter int FRAME_BYTES   = 25,
   parameter int CHANNEL_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  sfd_pkg::entry_type pop_entry,
   output logic               pop,
   input  sfd_pkg::cfg_type   cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_channel_number,
   output logic signed [11:0] rsp_channel_value,
   output logic               rsp_digital_one,
   output logic               rsp_digital_two,
   output logic               rsp_lost_frame,
   output logic               rsp_failsafe_active,
   output logic               rsp_final_channel
);
   import sfd_pkg::*;

   localparam int LAST      = FRAME_BYTES - 1;
   localparam int FLAG_SLOT = FRAME_BYTES - 2;
   localparam int PAY_BITS  = CHANNEL_COUNT * CHAN_BITS;
   localparam int PAY_BYTES = (PAY_BITS + 7) / 8;

   logic [7:0]             store_ff [FRAME_BYTES];
   logic [PAY_BYTES*8-1:0] gather;
   logic [PAY_BITS-1:0]    payload_ff;
   logic [3:0]             flags_ff;
   logic                   busy_ff;
   logic [NUMBER_BITS-1:0] ch_ff;
   logic                   load, ch_last, start;
   logic [VALUE_BITS-1:0]  diff;

   logic                   rsp_valid_ff;
   logic [NUMBER_BITS-1:0] rsp_number_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff;
   logic [3:0]             rsp_flags_ff;
   logic                   rsp_final_ff;

   assign pop     = !busy_ff && !empty;
   assign start   = pop && pop_entry.complete;
   assign load    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign ch_last = (ch_ff == NUMBER_BITS'(CHANNEL_COUNT - 1));

   // frame store, one byte per slot
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            if (pop_entry.pos == POS_BITS'(i)) begin
               store_ff[i] <= pop_entry.data;
            end
         end
      end
   end

   // payload bytes from slot 1 on; the completing footer is still in flight
   for (genvar j = 0; j < PAY_BYTES; j++) begin : g_gather
      if (j + 1 < LAST) begin : g_store
         assign gather[j*8 +: 8] = store_ff[j+1];
      end else if (j + 1 == LAST) begin : g_footer
         assign gather[j*8 +: 8] = pop_entry.data;
      end else begin : g_short
         assign gather[j*8 +: 8] = 8'h00;
      end
   end

   // low channel minus neutral value
   assign diff = {1'b0, payload_ff[CHAN_BITS-1:0]} - {1'b0, cfg.neutral_offset};

   // unpack shift register and channel flags
   always_ff @(posedge clock) begin
      if (start) begin
         payload_ff <= gather[PAY_BITS-1:0];
         flags_ff   <= store_ff[FLAG_SLOT][7:4];
      end else if (load) begin
         payload_ff <= payload_ff >> CHAN_BITS;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_number_ff <= ch_ff;
         rsp_value_ff  <= diff;
         rsp_flags_ff  <= flags_ff;
         rsp_final_ff  <= ch_last;
      end
   end

   // channel sequencer and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            ch_ff   <= '0;
         end else if (load) begin
            ch_ff <= ch_ff + 1'b1;
            if (ch_last) busy_ff <= 1'b0;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel_number  = rsp_number_ff;
   assign rsp_channel_value   = rsp_value_ff;
   assign rsp_digital_one     = rsp_flags_ff[3];
   assign rsp_digital_two     = rsp_flags_ff[2];
   assign rsp_lost_frame      = rsp_flags_ff[1];
   assign rsp_failsafe_active = rsp_flags_ff[0];
   assign rsp_final_channel   = rsp_final_ff;

   `SFD_ASSERT(a_final_number, (rsp_valid_ff && rsp_final_ff) |-> (rsp_number_ff == NUMBER_BITS'(CHANNEL_COUNT - 1)), "final flag on wrong channel")
   `SFD_ASSERT_NEXT(a_busy_ends, load && ch_last, !busy_ff, "sequencer still busy after last channel")

endmodule

### hdl/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// Serial radio-control frame decoder.
// req channel: one received UART byte per request (valid/ready). The front end
// tracks the frame position (header after footer restarts it, otherwise it
// advances and wraps after the last slot) and queues each byte with its slot.
// The back end stores the bytes; when the last slot receives a footer byte it
// unpacks CHANNEL_COUNT 11-bit channels, one per cycle from a shift register,
// and returns them on the rsp channel with the flag byte bits; final_channel
// marks the last one.
// The accepted footer byte passes from the queue into the back end, which loads
// the shift register and flags, then the result register; then one result per
// cycle while rsp_ready allows, paced by the channel sequencer. A 4-entry queue
// keeps accepting bytes meanwhile; req_ready drops only when it is full.
// A stalled receiver holds the result register; the sequencer waits on it.
// Reset clears position (0), previous byte (0xFF), queue and registers to
// header 0x0F, footer 0x00, neutral offset 992. Registers: APB at 0x0, 0x4, 0x8.
module sbus_frame_decoder #(
   parameter int FRAME_BYTES   = 25,
   parameter int CHANNEL_COUNT = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_received_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [3:0]                          rsp_channel_number,
   output logic signed [11:0]                  rsp_channel_value,
   output logic                                rsp_digital_one,
   output logic                                rsp_digital_two,
   output logic                                rsp_lost_frame,
   output logic                                rsp_failsafe_active,
   output logic                                rsp_final_channel,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sfd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sfd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sfd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import sfd_pkg::*;

   logic [7:0]           header_ff, footer_ff;
   logic [CHAN_BITS-1:0] neutral_ff;
   logic                 csr_write;
   logic [1:0]           csr_index;
   cfg_type              cfg;
   entry_type            push_entry, pop_entry;
   logic                 push, pop, full, empty;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         footer_ff  <= FOOTER_RESET;
         neutral_ff <= NEUTRAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_HEADER:  header_ff  <= csr_pwdata[7:0];
            REG_FOOTER:  footer_ff  <= csr_pwdata[7:0];
            REG_NEUTRAL: neutral_ff <= csr_pwdata[CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HEADER:  csr_prdata = {{(CSR_DATA_BITS-8){1'b0}}, header_ff};
         REG_FOOTER:  csr_prdata = {{(CSR_DATA_BITS-8){1'b0}}, footer_ff};
         REG_NEUTRAL: csr_prdata = {{(CSR_DATA_BITS-CHAN_BITS){1'b0}}, neutral_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign cfg.header_value   = header_ff;
   assign cfg.footer_value   = footer_ff;
   assign cfg.neutral_offset = neutral_ff;

   sfd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_received_byte (req_received_byte),
      .cfg               (cfg),
      .full              (full),
      .push              (push),
      .push_entry        (push_entry)
   );

   sfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   sfd_back #(
      .FRAME_BYTES   (FRAME_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .empty               (empty),
      .pop_entry           (pop_entry),
      .pop                 (pop),
      .cfg                 (cfg),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_number  (rsp_channel_number),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_digital_one     (rsp_digital_one),
      .rsp_digital_two     (rsp_digital_two),
      .rsp_lost_frame      (rsp_lost_frame),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_final_channel   (rsp_final_channel)
   );

endmodule
